@@ rtl/rtucrc_pkg.sv @@
// rtucrc_pkg: shared types, constants and the crc-16 byte update function
// for the rtu crc-16 frame codec; no dependencies
package rtucrc_pkg;

  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam int unsigned MAX_RES   = 3;
  localparam int unsigned RES_IDX_W = $clog2(MAX_RES);
  localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_SHORT   = 2'd1,
    STATUS_CRC_ERR = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       is_address;
    logic       frame_end;
    status_e    status;
    logic       run_last;
  } result_t;

  typedef struct packed {
    result_t [MAX_RES-1:0]  res;
    logic [RES_CNT_W-1:0]   count;
  } bundle_t;

  // reflected crc-16, one byte, lsb first
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/rtucrc_frame.sv @@
// rtucrc_frame: frame state (crc, two-byte delay line, start flag) and the
// result bundle of one request; depends on rtucrc_pkg
module rtucrc_frame (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  input  logic                append_mode_i,
  input  logic                clear_i,
  output rtucrc_pkg::bundle_t bundle_o
);
  import rtucrc_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic [7:0]  held0_q, held0_d, held1_q, held1_d;
  logic [1:0]  held_cnt_q, held_cnt_d;
  logic        started_q, started_d;

  logic        full;
  logic [7:0]  emit_byte;
  logic [15:0] crc_n;
  logic [15:0] rx_crc;
  result_t     r_emit;

  assign full      = held_cnt_q[1];
  assign emit_byte = append_mode_i ? data_byte_i : held0_q;
  assign crc_n     = crc_update(crc_q, emit_byte);
  assign rx_crc    = {data_byte_i, held1_q};

  always_comb begin
    r_emit            = '0;
    r_emit.out_byte   = emit_byte;
    r_emit.byte_valid = 1'b1;
    r_emit.is_address = ~started_q;
    r_emit.status     = STATUS_OK;
  end

  always_comb begin
    bundle_o = '0;
    for (int k = 0; k < MAX_RES; k++) begin
      bundle_o.res[k].status = STATUS_OK;
    end
    if (append_mode_i) begin
      bundle_o.res[0] = r_emit;
      if (last_byte_i) begin
        bundle_o.res[1].out_byte   = crc_n[7:0];
        bundle_o.res[1].byte_valid = 1'b1;
        bundle_o.res[2].out_byte   = crc_n[15:8];
        bundle_o.res[2].byte_valid = 1'b1;
        bundle_o.res[2].frame_end  = 1'b1;
        bundle_o.res[2].run_last   = 1'b1;
        bundle_o.count             = RES_CNT_W'(3);
      end else begin
        bundle_o.res[0].run_last = 1'b1;
        bundle_o.count           = RES_CNT_W'(1);
      end
    end else if (!last_byte_i) begin
      if (full) begin
        bundle_o.res[0]          = r_emit;
        bundle_o.res[0].run_last = 1'b1;
        bundle_o.count           = RES_CNT_W'(1);
      end
    end else if (full && started_q) begin
      bundle_o.res[0]           = r_emit;
      bundle_o.res[1].frame_end = 1'b1;
      bundle_o.res[1].status    = (rx_crc == crc_n) ? STATUS_OK : STATUS_CRC_ERR;
      bundle_o.res[1].run_last  = 1'b1;
      bundle_o.count            = RES_CNT_W'(2);
    end else begin
      bundle_o.res[0].frame_end = 1'b1;
      bundle_o.res[0].status    = STATUS_SHORT;
      bundle_o.res[0].run_last  = 1'b1;
      bundle_o.count            = RES_CNT_W'(1);
    end
  end

  always_comb begin
    crc_d      = crc_q;
    held0_d    = held0_q;
    held1_d    = held1_q;
    held_cnt_d = held_cnt_q;
    started_d  = started_q;
    if (clear_i || (accept_i && last_byte_i)) begin
      crc_d      = CRC_INIT;
      held0_d    = '0;
      held1_d    = '0;
      held_cnt_d = '0;
      started_d  = 1'b0;
    end else if (accept_i) begin
      if (append_mode_i || full) begin
        crc_d     = crc_n;
        started_d = 1'b1;
      end
      if (!append_mode_i) begin
        if (full) begin
          held0_d = held1_q;
          held1_d = data_byte_i;
        end else begin
          if (held_cnt_q[0]) begin
            held1_d = data_byte_i;
          end else begin
            held0_d = data_byte_i;
          end
          held_cnt_d = held_cnt_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= CRC_INIT;
      held0_q    <= '0;
      held1_q    <= '0;
      held_cnt_q <= '0;
      started_q  <= 1'b0;
    end else begin
      crc_q      <= crc_d;
      held0_q    <= held0_d;
      held1_q    <= held1_d;
      held_cnt_q <= held_cnt_d;
      started_q  <= started_d;
    end
  end

endmodule

@@ rtl/rtucrc_outbuf.sv @@
// rtucrc_outbuf: result register bank holding the up to three results of
// one request, drained one per cycle unless stalled; uses rtucrc_pkg
module rtucrc_outbuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  rtucrc_pkg::bundle_t bundle_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic                busy_o,
  output rtucrc_pkg::result_t res_o
);
  import rtucrc_pkg::*;

  result_t [MAX_RES-1:0]  res_q, res_d;
  logic [RES_CNT_W-1:0]   rem_q, rem_d;
  logic [RES_IDX_W-1:0]   idx_q, idx_d;
  logic                   pop;

  assign out_valid_o = (rem_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  // free once the last pending result leaves this cycle
  assign busy_o      = out_valid_o && !(pop && rem_q == RES_CNT_W'(1));
  assign res_o       = res_q[idx_q];

  always_comb begin
    res_d = res_q;
    rem_d = rem_q;
    idx_d = idx_q;
    if (load_i) begin
      res_d = bundle_i.res;
      rem_d = bundle_i.count;
      idx_d = '0;
    end else if (pop) begin
      rem_d = rem_q - RES_CNT_W'(1);
      idx_d = idx_q + RES_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      idx_q <= '0;
    end else begin
      rem_q <= rem_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

@@ rtl/rtu_crc16_frame_codec.sv @@
// rtu_crc16_frame_codec: top level, uses rtucrc_pkg, rtucrc_frame and rtucrc_outbuf
// output: the first result of a request is registered and on the outputs in the cycle after accept
// throughput: one request per cycle while each makes at most one result and the
//   output does not stall; a request making two results (check-mode close with a crc
//   check) or three (append-mode close) holds off the next request until they drain
// reset: rst_ni async active low; crc to 0xFFFF, delay line empty, check mode
module rtu_crc16_frame_codec (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration: append_mode register
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  // input requests
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  // result requests
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       is_address_o,
  output logic       frame_end_o,
  output logic [1:0] status_o,
  output logic       run_last_o
);
  import rtucrc_pkg::*;

  logic    append_mode_q;
  logic    accept;
  logic    busy;
  bundle_t bundle;
  result_t res;

  // mode register; any write also aborts the open frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      append_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      append_mode_q <= cfg_wdata_i;
    end
  end

  // a request is taken whenever the result bank is empty or emptying now
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  // single pass: crc byte update, delay line and result build
  rtucrc_frame u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .append_mode_i (append_mode_q),
    .clear_i       (cfg_we_i),
    .bundle_o      (bundle)
  );

  // result registers, drained in order
  rtucrc_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .bundle_i    (bundle),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .busy_o      (busy),
    .res_o       (res)
  );

  assign out_byte_o   = res.out_byte;
  assign byte_valid_o = res.byte_valid;
  assign is_address_o = res.is_address;
  assign frame_end_o  = res.frame_end;
  assign status_o     = res.status;
  assign run_last_o   = res.run_last;

  // frame close is always the last result of its request
  a_end_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> run_last_o)
    else $error("frame end not flagged as last result");

  // address flag only on a real byte
  a_addr_has_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_address_o) |-> byte_valid_o)
    else $error("address flag without byte");

  // non-ok status only at frame end
  a_status_at_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STATUS_OK) |-> frame_end_o)
    else $error("status outside frame end");

  // empty result bank never stalls the input
  a_no_idle_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with no pending result");

endmodule
